@@ rtl/ats_pkg.sv @@
// Shared types and constants for the averaged temperature sensor.
// No dependencies; every other file of the block imports this package.
package ats_pkg;

    localparam int SAMPLE_W = 10;
    localparam int PERIOD_W = 16;
    localparam int REF_W    = 13;
    localparam int TICK_W   = 17;
    localparam int TC_W     = 17;
    localparam int TF_W     = 18;
    localparam int MV_W     = 16;
    localparam int CW_W     = 21;
    localparam int C9_W     = 22;
    localparam int FW_W     = 20;
    localparam int F_DIV_W  = 21;
    localparam int DVS_W    = 7;
    localparam int Q_DEPTH  = 2;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic signed [CW_W-1:0] CW_MAX    = 21'sd65535;
    localparam logic signed [CW_W-1:0] CW_MIN    = -21'sd65536;
    localparam logic signed [CW_W-1:0] MV_OFFSET = 21'sd500;
    localparam logic signed [CW_W-1:0] C_SCALE   = 21'sd10;

    localparam logic signed [C9_W-1:0] F_MUL   = 22'sd9;
    // 5 * 117965: lifts every c*9 above zero so that truncation equals floor
    localparam logic signed [C9_W-1:0] F_BIAS  = 22'sd589825;
    // removes the bias quotient (117965) and adds 32 F (3200)
    localparam logic signed [FW_W-1:0] F_SHIFT = 20'sd114765;
    localparam logic [DVS_W-1:0]       F_DIV   = 7'd5;

    localparam logic signed [TC_W-1:0] C_RESET = 17'sd2500;
    localparam logic signed [TF_W-1:0] F_RESET = 18'sd7700;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [REF_W-1:0]    REF_RESET    = 13'd5000;

    localparam logic REG_SAMPLE_PERIOD = 1'b0;
    localparam logic REG_ADC_REF       = 1'b1;

    typedef struct packed {
        logic                take;
        logic [SAMPLE_W-1:0] sample;
    } tick_t;

    typedef struct packed {
        logic start;
        logic by_five;
    } div_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_MUL,
        S_DIV_MV,
        S_WAIT_MV,
        S_DIV_F,
        S_WAIT_F,
        S_DONE
    } back_state_t;

endpackage

@@ rtl/ats_front.sv @@
// Front end: takes tick transfers, runs the elapsed-tick counter and marks sampling ticks.
// Depends on ats_pkg.
module ats_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ats_pkg::SAMPLE_W-1:0] adc_sample,
    input  logic [ats_pkg::PERIOD_W-1:0] sample_period,
    input  logic                         q_full,
    output logic                         push,
    output ats_pkg::tick_t               push_data
);
    import ats_pkg::*;

    logic [TICK_W-1:0] elapsed_reg;
    logic [TICK_W-1:0] elapsed_next;
    logic [TICK_W-1:0] elapsed_inc;
    logic              take;

    assign s_tready    = !q_full;
    assign push        = s_tvalid && s_tready;
    // saturate rather than wrap
    assign elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign take        = elapsed_inc > {1'b0, sample_period};

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (push)
        begin
            elapsed_next = take ? '0 : elapsed_inc;
        end
    end

    assign push_data.take   = take;
    assign push_data.sample = adc_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

@@ rtl/ats_queue.sv @@
// Two-entry queue of classified ticks between front and back end.
// Depends on ats_pkg.
module ats_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ats_pkg::tick_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output ats_pkg::tick_t head
);
    import ats_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    tick_t          entry_reg [Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full  = count_reg == CW'(Q_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/ats_div.sv @@
// Shared constant divider, by WINDOW or by five, using reciprocal multiplication.
// Depends on ats_pkg.
module ats_div #(
    parameter int DIV_W  = 21,
    parameter int WINDOW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ats_pkg::div_req_t    req,
    input  logic [DIV_W-1:0]     dividend,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);
    import ats_pkg::*;

    // floor(x * ceil(2^k / d) / 2^k) equals floor(x / d) for every x below 2^DIV_W
    // as long as 2^(k - DIV_W) is at least d
    localparam int     SH_WIN   = DIV_W + $clog2(WINDOW);
    localparam int     SH_FIVE  = DIV_W + $clog2(F_DIV);
    localparam int     RCP_W    = DIV_W + 1;
    localparam int     PROD_W   = DIV_W + RCP_W;
    localparam longint RCP_WIN  = ((longint'(1) << SH_WIN) + WINDOW - 1) / WINDOW;
    localparam longint RCP_FIVE = ((longint'(1) << SH_FIVE) + longint'(F_DIV) - 1) /
                                  longint'(F_DIV);

    logic              busy_reg;
    logic              done_reg;
    logic              by_five_reg;
    logic [DIV_W-1:0]  num_reg;
    logic [RCP_W-1:0]  rcp;
    logic [PROD_W-1:0] prod_reg;

    assign rcp = by_five_reg ? RCP_W'(RCP_FIVE) : RCP_W'(RCP_WIN);

    assign done     = done_reg;
    assign quotient = by_five_reg ? DIV_W'(prod_reg >> SH_FIVE) : DIV_W'(prod_reg >> SH_WIN);

    // capture the operand, multiply on the next cycle and hold the product
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg     <= dividend;
            by_five_reg <= req.by_five;
        end
        if (busy_reg)
        begin
            prod_reg <= PROD_W'(num_reg) * PROD_W'(rcp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= req.start;
            done_reg <= busy_reg;
        end
    end

endmodule

@@ rtl/ats_back.sv @@
// Back end: sample ring, running sum, voltage and temperature conversion, output register.
// Depends on ats_pkg and ats_div.
module ats_back #(
    parameter int WINDOW     = 8,
    parameter int ADC_BITS   = 10,
    parameter int INIT_COUNT = 153
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ats_pkg::REF_W-1:0]       adc_ref_mv,
    input  logic                            q_empty,
    input  ats_pkg::tick_t                  q_head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [ats_pkg::TC_W-1:0] temp_c_centi,
    output logic signed [ats_pkg::TF_W-1:0] temp_f_centi,
    output logic                            sample_taken
);
    import ats_pkg::*;

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = $clog2(WINDOW * 1023 + 1);
    localparam int PROD_W = SUM_W + REF_W;
    localparam int Q_W    = PROD_W - ADC_BITS;
    localparam int DIV_W  = (Q_W > F_DIV_W) ? Q_W : F_DIV_W;

    back_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0]    ring_mem [WINDOW];
    logic [SAMPLE_W-1:0]    rd_reg;
    logic [WINDOW-1:0]      valid_reg, valid_next;
    logic                   old_valid_reg;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_W-1:0]    sample_reg, sample_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [TC_W-1:0] c_reg, c_next;
    logic signed [TC_W-1:0] celsius_reg, celsius_next;
    logic signed [TF_W-1:0] fahrenheit_reg, fahrenheit_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [TC_W-1:0] out_c_reg, out_c_next;
    logic signed [TF_W-1:0] out_f_reg, out_f_next;
    logic                   out_taken_reg, out_taken_next;

    logic                   mem_wr;
    logic                   out_free;
    logic [SAMPLE_W-1:0]    old_sample;
    div_req_t               div_req;
    logic [DIV_W-1:0]       div_dividend;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quo;
    logic [MV_W-1:0]        mv;
    logic signed [CW_W-1:0] cw;
    logic signed [C9_W-1:0] c9;
    logic signed [C9_W-1:0] c9_biased;
    logic signed [FW_W-1:0] fw;

    ats_div #(
        .DIV_W  (DIV_W),
        .WINDOW (WINDOW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign mem_wr     = state_reg == S_SUM;
    assign old_sample = old_valid_reg ? rd_reg : SAMPLE_W'(INIT_COUNT);

    assign mv        = div_quo[MV_W-1:0];
    assign cw        = ($signed({5'b0, mv}) - MV_OFFSET) * C_SCALE;
    assign c9        = C9_W'(c_reg) * F_MUL;
    assign c9_biased = c9 + F_BIAS;
    assign fw        = $signed({1'b0, div_quo[TF_W-1:0]}) - F_SHIFT;

    assign out_valid    = out_valid_reg;
    assign temp_c_centi = out_c_reg;
    assign temp_f_centi = out_f_reg;
    assign sample_taken = out_taken_reg;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        ptr_next        = ptr_reg;
        sum_next        = sum_reg;
        sample_next     = sample_reg;
        prod_next       = prod_reg;
        c_next          = c_reg;
        celsius_next    = celsius_reg;
        fahrenheit_next = fahrenheit_reg;
        out_valid_next  = out_valid_reg;
        out_c_next      = out_c_reg;
        out_f_next      = out_f_reg;
        out_taken_next  = out_taken_reg;
        pop             = 1'b0;
        div_req         = '0;
        div_dividend    = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && (q_head.take || out_free))
                begin
                    pop         = 1'b1;
                    sample_next = q_head.sample;
                    if (q_head.take)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_c_next     = celsius_reg;
                        out_f_next     = fahrenheit_reg;
                        out_taken_next = 1'b0;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next            = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                valid_next[ptr_reg] = 1'b1;
                ptr_next   = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(sum_reg) * PROD_W'(adc_ref_mv);
                state_next = S_DIV_MV;
            end
            S_DIV_MV:
            begin
                div_req.start   = 1'b1;
                div_req.by_five = 1'b0;
                div_dividend    = DIV_W'(prod_reg[PROD_W-1:ADC_BITS]);
                state_next      = S_WAIT_MV;
            end
            S_WAIT_MV:
            begin
                if (div_done)
                begin
                    if (cw > CW_MAX)
                    begin
                        c_next = CW_MAX[TC_W-1:0];
                    end
                    else if (cw < CW_MIN)
                    begin
                        c_next = CW_MIN[TC_W-1:0];
                    end
                    else
                    begin
                        c_next = cw[TC_W-1:0];
                    end
                    state_next = S_DIV_F;
                end
            end
            S_DIV_F:
            begin
                div_req.start   = 1'b1;
                div_req.by_five = 1'b1;
                div_dividend    = DIV_W'(c9_biased[F_DIV_W-1:0]);
                state_next      = S_WAIT_F;
            end
            S_WAIT_F:
            begin
                if (div_done)
                begin
                    celsius_next    = c_reg;
                    fahrenheit_next = fw[TF_W-1:0];
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_c_next     = celsius_reg;
                    out_f_next     = fahrenheit_reg;
                    out_taken_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            ring_mem[ptr_reg] <= sample_reg;
        end
        if (state_reg == S_READ)
        begin
            rd_reg        <= ring_mem[ptr_reg];
            old_valid_reg <= valid_reg[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        prod_reg   <= prod_next;
        c_reg      <= c_next;
        out_c_reg  <= out_c_next;
        out_f_reg  <= out_f_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            ptr_reg        <= '0;
            sum_reg        <= SUM_W'(WINDOW * INIT_COUNT);
            celsius_reg    <= C_RESET;
            fahrenheit_reg <= F_RESET;
            out_valid_reg  <= 1'b0;
            out_taken_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            ptr_reg        <= ptr_next;
            sum_reg        <= sum_next;
            celsius_reg    <= celsius_next;
            fahrenheit_reg <= fahrenheit_next;
            out_valid_reg  <= out_valid_next;
            out_taken_reg  <= out_taken_next;
        end
    end

endmodule

@@ rtl/averaged_temperature_sensor_top.sv @@
// Top level of the averaged temperature sensor: register port, front end, queue, back end.
// Depends on ats_pkg, ats_front, ats_queue and ats_back.
//
// Usage: each transfer on the slave stream (s_tvalid/s_tready, s_tdata) is one time tick
// carrying the current converter reading. Every tick yields exactly one transfer on the
// master stream (m_tvalid/m_tready): m_tdata carries the Celsius and Fahrenheit readings in
// hundredths of a degree, m_tuser flags a tick that took a new sample into the window.
// Ticks that take no sample repeat the last computed temperatures.
// The user must see that sample_period and adc_ref_mv are written over the APB port
// only while the block is idle; the block itself does not enforce this. A tick without
// a sample passes through the queue and then into the output register. A sampling tick
// runs ring read, sum update, one multiply and two passes of the shared reciprocal
// divider (by WINDOW, then by five for Fahrenheit); S_DONE then loads its result.
// Throughput: one tick per cycle without samples while the output is free; a sampling
// tick holds the back end. A two-entry queue lets the front keep taking ticks meanwhile.
// Reset: the window reads as INIT_COUNT in every slot, temperatures start at 25 C / 77 F,
// registers return to their defaults and the tick counter clears.
// Stall: the result waits in the output register; the back end halts when it cannot
// load the next result, the queue fills and s_tready drops.
module averaged_temperature_sensor_top #(
    parameter int WINDOW     = 8,
    parameter int ADC_BITS   = 10,
    parameter int INIT_COUNT = 153
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // tick stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [16:0] temp_c_centi, [34:17] temp_f_centi, [39:35] zero
    output logic        m_tuser    // [0] sample_taken
);
    import ats_pkg::*;

    logic [PERIOD_W-1:0]    period_reg;
    logic [REF_W-1:0]       ref_reg;
    logic                   cfg_wr;
    logic                   reg_idx;

    logic                   q_full;
    logic                   q_empty;
    logic                   push;
    logic                   pop;
    tick_t                  push_data;
    tick_t                  q_head;

    logic signed [TC_W-1:0] temp_c;
    logic signed [TF_W-1:0] temp_f;

    // registers sit at byte addresses 0 and 4
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_idx)
            REG_SAMPLE_PERIOD: prdata = {16'b0, period_reg};
            REG_ADC_REF:       prdata = {19'b0, ref_reg};
            default:           prdata = '0;
        endcase
    end

    // write on the access cycle of the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            ref_reg    <= REF_RESET;
        end
        else if (cfg_wr && pready)
        begin
            if (reg_idx == REG_SAMPLE_PERIOD)
            begin
                period_reg <= pwdata[PERIOD_W-1:0];
            end
            else
            begin
                ref_reg <= pwdata[REF_W-1:0];
            end
        end
    end

    // classify ticks and count elapsed time
    ats_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .adc_sample    (s_tdata[SAMPLE_W-1:0]),
        .sample_period (period_reg),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    // decouple the front from the slow arithmetic
    ats_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // filter, convert and hold the result
    ats_back #(
        .WINDOW     (WINDOW),
        .ADC_BITS   (ADC_BITS),
        .INIT_COUNT (INIT_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .adc_ref_mv   (ref_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .temp_c_centi (temp_c),
        .temp_f_centi (temp_f),
        .sample_taken (m_tuser)
    );

    assign m_tdata = {5'b0, temp_f, temp_c};

endmodule

@@ rtl/ats_checker.sv @@
// Port-level checks for the averaged temperature sensor, bound to the top level.
// Depends on ats_pkg and averaged_temperature_sensor_top.
module ats_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);
    import ats_pkg::*;

    logic [2:0]            pending_reg;
    logic [TF_W+TC_W-1:0]  last_reg;
    logic                  in_xfer;
    logic                  out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            last_reg    <= {F_RESET, C_RESET};
        end
        else
        begin
            if (in_xfer && !out_xfer)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (out_xfer && !in_xfer)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (out_xfer)
            begin
                last_reg <= m_tdata[TF_W+TC_W-1:0];
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> pending_reg != 3'd0)
        else $error("result without a pending tick");

    a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !m_tuser |-> m_tdata[TF_W+TC_W-1:0] == last_reg)
        else $error("idle tick did not repeat the last temperatures");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:TF_W+TC_W] == '0)
        else $error("padding bits set");

endmodule

bind averaged_temperature_sensor_top ats_checker u_ats_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ dv/testbench.sv @@
// Self-checking testbench for averaged_temperature_sensor_top: ticks go in over the
// slave stream, and each temperature transfer is checked against an in-bench predictor.
// Depends on ats_pkg and the RTL of the block; reads no files.
module testbench;
    import ats_pkg::*;

    localparam int WINDOW      = 8;
    localparam int ADC_BITS    = 10;
    localparam int INIT_COUNT  = 153;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_GAP   = 64;    // longer than one sampling tick through the divider
    localparam int HOLD_CYCLES = 300;

    localparam logic [2:0] ADDR_SAMPLE_PERIOD = {REG_SAMPLE_PERIOD, 2'b00};
    localparam logic [2:0] ADDR_ADC_REF       = {REG_ADC_REF, 2'b00};

    typedef struct packed {
        logic signed [TC_W-1:0] celsius;
        logic signed [TF_W-1:0] fahrenheit;
        logic                   taken;
    } temp_reading_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [9:0] adc_sample, [15:10] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [16:0] temp_c_centi, [34:17] temp_f_centi, [39:35] zero
    logic        m_tuser;   // [0] sample_taken

    // Predictor state: sample window, running sum, tick counter, last temperatures
    logic [SAMPLE_W-1:0] win_slots [WINDOW];
    int                  win_ptr;
    int unsigned         win_sum;
    int unsigned         tick_count;
    longint              celsius_last;
    longint              fahr_last;
    int unsigned         period_cfg;
    int unsigned         ref_cfg;

    temp_reading_t readings_due[$];

    int  fail_count;
    int  ticks_sent;
    int  samples_seen;
    int  saturated_seen;
    int  cycles;
    bit  idle_on;
    bit  hold_req;
    int  run_left;
    logic [SAMPLE_W-1:0] run_val;

    averaged_temperature_sensor_top #(
        .WINDOW     (WINDOW),
        .ADC_BITS   (ADC_BITS),
        .INIT_COUNT (INIT_COUNT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: end the run if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d readings outstanding",
                     cycles, readings_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Advance the sensor by one tick and return the reading it should publish
    task automatic predict_reading(input logic [SAMPLE_W-1:0] adc, output temp_reading_t r);
        longint mv;
        longint c;
        longint c9;
        longint fq;
        begin
            r.taken = 1'b0;
            if (tick_count < (1 << TICK_W) - 1)
                tick_count++;
            if (tick_count > period_cfg)
            begin
                win_sum = win_sum - win_slots[win_ptr] + adc;
                win_slots[win_ptr] = adc;
                win_ptr = (win_ptr + 1) % WINDOW;
                tick_count = 0;
                mv = (longint'(win_sum) * longint'(ref_cfg)) / (longint'(WINDOW) << ADC_BITS);
                c = (mv - 500) * 10;
                // clamp Celsius to the 17-bit signed field; Fahrenheit follows the clamp
                if (c > 65535)
                    c = 65535;
                if (c < -65536)
                    c = -65536;
                c9 = c * 9;
                fq = c9 / 5;
                if (c9 < 0 && (c9 % 5) != 0)
                    fq--;
                celsius_last = c;
                fahr_last = fq + 3200;
                r.taken = 1'b1;
            end
            r.celsius = TC_W'(celsius_last);
            r.fahrenheit = TF_W'(fahr_last);
        end
    endtask

    // Offer one tick and hold it until the transfer happens
    task automatic send_tick(input logic [SAMPLE_W-1:0] adc);
        temp_reading_t r;
        begin
            s_tvalid <= 1'b1;
            s_tdata <= {6'b0, adc};
            do
                @(posedge clk);
            while (!s_tready);
            predict_reading(adc, r);
            readings_due.push_back(r);
            ticks_sent++;
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
        end
    endtask

    // Drop valid so no stale tick is taken
    task automatic sender_rest();
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            while (readings_due.size() != 0)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= addr;
            pwdata <= value;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (addr == ADDR_SAMPLE_PERIOD)
                period_cfg = value[PERIOD_W-1:0];
            else if (addr == ADDR_ADC_REF)
                ref_cfg = value[REF_W-1:0];
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Let the block go idle, then load both registers
    task automatic configure(input int unsigned period, input int unsigned ref_mv);
        begin
            sender_rest();
            wait_drained();
            repeat (DRAIN_GAP) @(negedge clk);
            write_reg(ADDR_SAMPLE_PERIOD, period);
            write_reg(ADDR_ADC_REF, ref_mv);
        end
    endtask

    // Mostly uniform readings, with runs pinned at either rail so the window
    // can fill completely and drive the average to its extremes
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int k;
        if (run_left > 0)
        begin
            run_left--;
            return run_val;
        end
        k = $urandom_range(0, 19);
        if (k == 0 || k == 1)
        begin
            run_val = (k == 0) ? '0 : '1;
            run_left = $urandom_range(7, 12);
            return run_val;
        end
        return SAMPLE_W'($urandom_range(0, 1023));
    endfunction

    task automatic random_phase(input int unsigned period, input int unsigned ref_mv,
                                input int count);
        begin
            configure(period, ref_mv);
            repeat (count) send_tick(pick_sample());
        end
    endtask

    // Ticks straight after reset take no sample and repeat 25 C / 77 F
    task automatic test_reset_values();
        begin
            repeat (4) send_tick(SAMPLE_W'($urandom_range(0, 1023)));
        end
    endtask

    // Rails, alternating bits, saturation and a period too long to reach
    task automatic test_directed_extremes();
        begin
            configure(0, 5000);
            send_tick(10'h000);
            send_tick(10'h3FF);
            send_tick(10'h2AA);
            send_tick(10'h155);
            send_tick(10'h001);
            send_tick(10'h200);
            // full-scale window with the widest reference: Celsius clamps
            configure(0, 8191);
            repeat (8) send_tick(10'h3FF);
            // every second tick samples
            configure(1, 1000);
            send_tick(10'h000);
            send_tick(10'h000);
            // longest period: none of these ticks samples
            configure(65535, 5500);
            repeat (3) send_tick(10'h3FF);
        end
    endtask

    task automatic test_random_sweep();
        begin
            idle_on = 1'b1;
            random_phase(0, 5000, 400);
            random_phase(1, 1000, 200);
            // a stretch with no idling on either side
            idle_on = 1'b0;
            random_phase(3, 5500, 200);
            idle_on = 1'b1;
            repeat (4)
                random_phase($urandom_range(0, 12), $urandom_range(1000, 5500), 100);
            random_phase(40, $urandom_range(1000, 5500), 150);
        end
    endtask

    // Stall the receiver long enough to back the block up, then pause the
    // sender until every reading is out and send a further run of ticks
    task automatic test_backpressure();
        begin
            configure(0, $urandom_range(1000, 5500));
            hold_req = 1'b1;
            repeat (60) send_tick(pick_sample());
            sender_rest();
            wait_drained();
            repeat (40) send_tick(pick_sample());
        end
    endtask

    task automatic test_final_calm();
        begin
            idle_on = 1'b0;
            random_phase(2, 8191, 200);
        end
    endtask

    // Receiver: random stall bursts, one long hold on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Checker: compare each result transfer with the oldest outstanding reading
    always @(posedge clk)
    begin
        temp_reading_t due;
        logic signed [TC_W-1:0] got_c;
        logic signed [TF_W-1:0] got_f;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_c = m_tdata[16:0];
            got_f = m_tdata[34:17];
            if (readings_due.size() == 0)
            begin
                $error("unexpected transfer: temp_c_centi %0d temp_f_centi %0d",
                       got_c, got_f);
                fail_count++;
            end
            else
            begin
                due = readings_due.pop_front();
                if (got_c !== due.celsius)
                begin
                    $error("temp_c_centi: expected %0d, got %0d", due.celsius, got_c);
                    fail_count++;
                end
                if (got_f !== due.fahrenheit)
                begin
                    $error("temp_f_centi: expected %0d, got %0d", due.fahrenheit, got_f);
                    fail_count++;
                end
                if (m_tuser !== due.taken)
                begin
                    $error("sample_taken: expected %0d, got %0d", due.taken, m_tuser);
                    fail_count++;
                end
                if (due.taken)
                    samples_seen++;
                if (due.taken && due.celsius == 17'sd65535)
                    saturated_seen++;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cycles = 0;
        fail_count = 0;
        ticks_sent = 0;
        samples_seen = 0;
        saturated_seen = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        run_left = 0;
        run_val = '0;
        // predictor starts from the reset image of the block
        for (int i = 0; i < WINDOW; i++)
            win_slots[i] = SAMPLE_W'(INIT_COUNT);
        win_ptr = 0;
        win_sum = WINDOW * INIT_COUNT;
        tick_count = 0;
        celsius_last = 2500;
        fahr_last = 7700;
        period_cfg = 1000;
        ref_cfg = 5000;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_directed_extremes();
        test_random_sweep();
        test_backpressure();
        test_final_calm();

        sender_rest();
        wait_drained();
        repeat (DRAIN_GAP) @(posedge clk);

        $display("Ran %0d ticks: %0d took a sample, %0d clamped at the Celsius ceiling,",
                 ticks_sent, samples_seen, saturated_seen);
        $display("periods 0 to 65535, references 1000 to 8191 mV, with a long output stall.");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ats_pkg.sv
rtl/ats_front.sv
rtl/ats_queue.sv
rtl/ats_div.sv
rtl/ats_back.sv
rtl/averaged_temperature_sensor_top.sv
rtl/ats_checker.sv
dv/testbench.sv
